/* sv/ofc_pkg.sv */
// Shared types and constants for the oriented box frustum classifier.
`timescale 1ns / 1ps
package ofc_pkg;

  localparam int PLANE_COUNT_DEF = 6;
  localparam int COORD_BITS_DEF = 16;

  localparam int COEF_BITS = 16;
  localparam int PLANE_BITS = 4 * COEF_BITS;
  localparam int REG_COUNT = 6;
  localparam int CFG_INDEX_BITS = 3;
  localparam int OFFSET_SHIFT = 14;
  localparam int VECTOR_COUNT = 4;
  localparam int AXIS_COUNT = 3;
  localparam int COORD_COUNT = VECTOR_COUNT * AXIS_COUNT;

  typedef enum logic [1:0] {
    PLACE_FRONT = 2'd0,
    PLACE_BACK  = 2'd1,
    PLACE_SPAN  = 2'd2
  } placement_t;

  typedef struct packed {
    logic product;
    logic dot;
    logic radius;
    logic compare;
  } ofc_adv_t;

endpackage

/* sv/ofc_plane_lane.sv */
// Four-stage datapath that tests one box against one plane.
`timescale 1ns / 1ps
module ofc_plane_lane #(
  parameter int COORD_BITS = ofc_pkg::COORD_BITS_DEF
) (
  input  logic                                            clk,
  input  ofc_pkg::ofc_adv_t                               adv,
  input  logic [ofc_pkg::PLANE_BITS-1:0]                  plane,
  input  logic [ofc_pkg::COORD_COUNT-1:0][COORD_BITS-1:0] coords,
  output logic                                            back,
  output logic                                            touch
);
  import ofc_pkg::*;

  localparam int PROD_W = COEF_BITS + COORD_BITS;
  localparam int DOT_W = PROD_W + 2;
  localparam int OFS_W = COEF_BITS + OFFSET_SHIFT;
  localparam int S_W = ((DOT_W > OFS_W) ? DOT_W : OFS_W) + 2;
  localparam int R_W = DOT_W + 2;
  localparam int CMP_W = ((S_W > R_W) ? S_W : R_W) + 1;

  logic signed [PROD_W-1:0]    prod [VECTOR_COUNT][AXIS_COUNT];
  logic signed [COEF_BITS-1:0] ofs1;
  logic signed [COEF_BITS-1:0] ofs2;
  logic signed [DOT_W-1:0]     dot  [VECTOR_COUNT];
  logic signed [R_W-1:0]       mag  [AXIS_COUNT];
  logic signed [R_W-1:0]       radius;
  logic signed [S_W-1:0]       distance;
  logic signed [CMP_W-1:0]     dist_cmp;
  logic signed [CMP_W-1:0]     radius_cmp;

  always_ff @(posedge clk) begin
    if (adv.product) begin
      for (int i = 0; i < VECTOR_COUNT; i++) begin
        for (int j = 0; j < AXIS_COUNT; j++) begin
          prod[i][j] <= $signed(plane[j*COEF_BITS +: COEF_BITS]) *
                        $signed(coords[i*AXIS_COUNT + j]);
        end
      end
      ofs1 <= $signed(plane[AXIS_COUNT*COEF_BITS +: COEF_BITS]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv.dot) begin
      for (int i = 0; i < VECTOR_COUNT; i++) begin
        dot[i] <= DOT_W'(prod[i][0]) + DOT_W'(prod[i][1]) + DOT_W'(prod[i][2]);
      end
      ofs2 <= ofs1;
    end
  end

  always_comb begin
    for (int k = 0; k < AXIS_COUNT; k++) begin
      mag[k] = dot[k+1][DOT_W-1] ? -R_W'(dot[k+1]) : R_W'(dot[k+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv.radius) begin
      radius   <= mag[0] + mag[1] + mag[2];
      distance <= S_W'(dot[0]) + (S_W'(ofs2) <<< OFFSET_SHIFT);
    end
  end

  assign dist_cmp   = CMP_W'(distance);
  assign radius_cmp = CMP_W'(radius);

  always_ff @(posedge clk) begin
    if (adv.compare) begin
      back  <= dist_cmp < -radius_cmp;
      touch <= dist_cmp <= radius_cmp;
    end
  end

endmodule

/* sv/obb_frustum_classify.sv */
// Top level of the oriented bounding box frustum classifier.
`timescale 1ns / 1ps
// Classifies an oriented bounding box (center plus three extent-scaled half-axes,
// Q12.4) against PLANE_COUNT planes (normal Q1.14, offset Q12.4) written through
// the configuration channel; planes beyond the six registers stay zero. The result
// is front, back or spanning. Every plane has its own lane, so one box is accepted
// each clock unless backpressure stalls it; the stages are products, dot sums,
// radius and distance, compares, and the output register that combines the lanes.
// Backpressure ripples back stage by stage, and an empty stage never stalls the
// stage before it. Configuration must be written only while no box is in flight.
module obb_frustum_classify #(
  parameter int PLANE_COUNT = ofc_pkg::PLANE_COUNT_DEF,
  parameter int COORD_BITS  = ofc_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ofc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [ofc_pkg::PLANE_BITS-1:0]      cfg_data,
  input  logic                                box_valid,
  output logic                                box_ready,
  input  logic signed [COORD_BITS-1:0]        center_x,
  input  logic signed [COORD_BITS-1:0]        center_y,
  input  logic signed [COORD_BITS-1:0]        center_z,
  input  logic signed [COORD_BITS-1:0]        half_axis0_x,
  input  logic signed [COORD_BITS-1:0]        half_axis0_y,
  input  logic signed [COORD_BITS-1:0]        half_axis0_z,
  input  logic signed [COORD_BITS-1:0]        half_axis1_x,
  input  logic signed [COORD_BITS-1:0]        half_axis1_y,
  input  logic signed [COORD_BITS-1:0]        half_axis1_z,
  input  logic signed [COORD_BITS-1:0]        half_axis2_x,
  input  logic signed [COORD_BITS-1:0]        half_axis2_y,
  input  logic signed [COORD_BITS-1:0]        half_axis2_z,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic [1:0]                          placement
);
  import ofc_pkg::*;

  localparam int STAGES = 5;

  logic [PLANE_BITS-1:0]                  plane_reg [REG_COUNT];
  logic [COORD_COUNT-1:0][COORD_BITS-1:0] coords;
  logic [STAGES-1:0]                      vld;
  logic [STAGES:0]                        rdy;
  ofc_adv_t                               adv;
  logic [PLANE_COUNT-1:0]                 back;
  logic [PLANE_COUNT-1:0]                 touch;
  placement_t                             placement_next;
  placement_t                             placement_reg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        plane_reg[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        if (cfg_index == CFG_INDEX_BITS'(i)) begin
          plane_reg[i] <= cfg_data;
        end
      end
    end
  end

  assign coords[0]  = center_x;
  assign coords[1]  = center_y;
  assign coords[2]  = center_z;
  assign coords[3]  = half_axis0_x;
  assign coords[4]  = half_axis0_y;
  assign coords[5]  = half_axis0_z;
  assign coords[6]  = half_axis1_x;
  assign coords[7]  = half_axis1_y;
  assign coords[8]  = half_axis1_z;
  assign coords[9]  = half_axis2_x;
  assign coords[10] = half_axis2_y;
  assign coords[11] = half_axis2_z;

  always_comb begin
    rdy[STAGES] = result_ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign box_ready   = rdy[0];
  assign adv.product = rdy[0];
  assign adv.dot     = rdy[1];
  assign adv.radius  = rdy[2];
  assign adv.compare = rdy[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= box_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_lane
    logic [PLANE_BITS-1:0] plane;
    if (p < REG_COUNT) begin : g_reg
      assign plane = plane_reg[p];
    end else begin : g_zero
      assign plane = '0;
    end
    ofc_plane_lane #(
      .COORD_BITS (COORD_BITS)
    ) u_lane (
      .clk    (clk),
      .adv    (adv),
      .plane  (plane),
      .coords (coords),
      .back   (back[p]),
      .touch  (touch[p])
    );
  end

  always_comb begin
    priority if (|back) begin
      placement_next = PLACE_BACK;
    end else if (|touch) begin
      placement_next = PLACE_SPAN;
    end else begin
      placement_next = PLACE_FRONT;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[STAGES-1]) begin
      placement_reg <= placement_next;
    end
  end

  assign placement    = placement_reg;
  assign result_valid = vld[STAGES-1];

`ifndef SYNTH
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    box_valid && box_ready |=> vld[0])
    else $error("An accepted transaction did not enter the first stage.");

  a_full_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !box_ready |-> (&vld) && !result_ready)
    else $error("Input stalled while the pipeline had room.");

  a_compare_holds: assert property (@(posedge clk) disable iff (rst)
    vld[STAGES-2] && !rdy[STAGES-1] |=> vld[STAGES-2])
    else $error("A stalled compare stage lost its transaction.");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(vld[STAGES-2]))
    else $error("A result appeared without a transaction in the compare stage.");
`endif

endmodule

/* bench/tb_obb_frustum_classify.sv */
// Self-checking testbench for the oriented bounding box frustum classifier.
`timescale 1ns / 1ps
module tb_obb_frustum_classify;
  import ofc_pkg::*;

  typedef logic [COORD_COUNT-1:0][COORD_BITS_DEF-1:0] box_t;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_PERCENT = 23;
  localparam logic [CFG_INDEX_BITS-1:0] UNUSED_INDEX_LO = CFG_INDEX_BITS'(REG_COUNT);
  localparam logic [CFG_INDEX_BITS-1:0] UNUSED_INDEX_HI =
    CFG_INDEX_BITS'((1 << CFG_INDEX_BITS) - 1);
  localparam logic [COEF_BITS-1:0] UNIT_NORMAL = 16'sd16384;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [PLANE_BITS-1:0] cfg_data = '0;
  logic box_valid = 1'b0;
  logic box_ready;
  box_t box_bus = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [1:0] placement;

  logic [PLANE_BITS-1:0] plane_word [8];
  placement_t placement_due [$];
  bit idle_on = 1'b1;
  int hold_left = 0;
  int cycle = 0;
  int mismatches = 0;
  int boxes_sent = 0;
  int plane_settings = 0;
  int seen_front = 0;
  int seen_back = 0;
  int seen_span = 0;

  obb_frustum_classify dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .box_valid(box_valid),
    .box_ready(box_ready),
    .center_x(box_bus[0]),
    .center_y(box_bus[1]),
    .center_z(box_bus[2]),
    .half_axis0_x(box_bus[3]),
    .half_axis0_y(box_bus[4]),
    .half_axis0_z(box_bus[5]),
    .half_axis1_x(box_bus[6]),
    .half_axis1_y(box_bus[7]),
    .half_axis1_z(box_bus[8]),
    .half_axis2_x(box_bus[9]),
    .half_axis2_y(box_bus[10]),
    .half_axis2_z(box_bus[11]),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .placement(placement)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle,
               placement_due.size());
      $display("tb_obb_frustum_classify: errors");
      $finish;
    end
  end

  function automatic longint coord(box_t b, int i);
    return longint'($signed(b[i]));
  endfunction

  function automatic longint coef(logic [PLANE_BITS-1:0] w, int i);
    return longint'($signed(w[i*COEF_BITS +: COEF_BITS]));
  endfunction

  function automatic placement_t predict_placement(box_t b);
    longint na, nb, nc, nd, radius, distance, proj;
    bit spans;
    spans = 1'b0;
    for (int p = 0; p < PLANE_COUNT_DEF; p++) begin
      na = coef(plane_word[p], 0);
      nb = coef(plane_word[p], 1);
      nc = coef(plane_word[p], 2);
      nd = coef(plane_word[p], 3);
      radius = 0;
      for (int k = 0; k < AXIS_COUNT; k++) begin
        proj = na * coord(b, 3 + 3 * k) + nb * coord(b, 4 + 3 * k) + nc * coord(b, 5 + 3 * k);
        radius += (proj < 0) ? -proj : proj;
      end
      distance = na * coord(b, 0) + nb * coord(b, 1) + nc * coord(b, 2) +
                 (nd <<< OFFSET_SHIFT);
      if (distance < -radius) return PLACE_BACK;
      if (distance <= radius) spans = 1'b1;
    end
    return spans ? PLACE_SPAN : PLACE_FRONT;
  endfunction

  function automatic logic [PLANE_BITS-1:0] pack_plane(int a, int b, int c, int d);
    return {d[COEF_BITS-1:0], c[COEF_BITS-1:0], b[COEF_BITS-1:0], a[COEF_BITS-1:0]};
  endfunction

  function automatic box_t make_box(int cx, int cy, int cz, int ax, int ay, int az,
                                    int bx, int by, int bz, int hx, int hy, int hz);
    box_t b;
    int v [COORD_COUNT];
    v = '{cx, cy, cz, ax, ay, az, bx, by, bz, hx, hy, hz};
    for (int i = 0; i < COORD_COUNT; i++) b[i] = v[i][COORD_BITS_DEF-1:0];
    return b;
  endfunction

  function automatic int rand_signed(int lim);
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  function automatic box_t near_box(int center_lim, int axis_lim);
    box_t b;
    for (int i = 0; i < COORD_COUNT; i++)
      b[i] = COORD_BITS_DEF'(rand_signed(i < AXIS_COUNT ? center_lim : axis_lim));
    return b;
  endfunction

  function automatic box_t wild_box();
    box_t b;
    for (int i = 0; i < COORD_COUNT; i++) b[i] = COORD_BITS_DEF'($urandom);
    return b;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < 100) $display("MISMATCH cycle %0d: %s", cycle, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    placement_t want;
    if (!rst && result_valid && result_ready) begin
      if (placement_due.size() == 0) begin
        report_mismatch($sformatf("placement %0d with no box outstanding", placement));
      end else begin
        want = placement_due.pop_front();
        if (placement !== want)
          report_mismatch($sformatf("placement %0d, expected %s", placement, want.name()));
        case (want)
          PLACE_FRONT: seen_front++;
          PLACE_BACK: seen_back++;
          default: seen_span++;
        endcase
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      result_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (idle_on) begin
      result_ready <= ($urandom_range(99) >= IDLE_PERCENT);
    end else begin
      result_ready <= 1'b1;
    end
  end

  task automatic send_box(box_t b);
    while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
      box_valid <= 1'b0;
      @(negedge clk);
    end
    box_valid <= 1'b1;
    box_bus <= b;
    do @(posedge clk); while (!box_ready);
    placement_due.push_back(predict_placement(b));
    boxes_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    box_valid <= 1'b0;
    while (placement_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [PLANE_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (index < REG_COUNT) plane_word[index] = value;
    @(negedge clk);
  endtask

  task automatic load_planes(logic [PLANE_BITS-1:0] planes [REG_COUNT]);
    for (int p = 0; p < REG_COUNT; p++) write_reg(CFG_INDEX_BITS'(p), planes[p]);
    cfg_valid <= 1'b0;
    plane_settings++;
    @(negedge clk);
  endtask

  task automatic load_cube(int half_width);
    logic [PLANE_BITS-1:0] planes [REG_COUNT];
    for (int k = 0; k < AXIS_COUNT; k++) begin
      planes[2*k] = '0;
      planes[2*k][k*COEF_BITS +: COEF_BITS] = UNIT_NORMAL;
      planes[2*k][3*COEF_BITS +: COEF_BITS] = COEF_BITS'(half_width);
      planes[2*k+1] = '0;
      planes[2*k+1][k*COEF_BITS +: COEF_BITS] = -UNIT_NORMAL;
      planes[2*k+1][3*COEF_BITS +: COEF_BITS] = COEF_BITS'(half_width);
    end
    load_planes(planes);
  endtask

  task automatic load_uniform(logic [COEF_BITS-1:0] value);
    logic [PLANE_BITS-1:0] planes [REG_COUNT];
    foreach (planes[p]) planes[p] = {4{value}};
    load_planes(planes);
  endtask

  task automatic test_reset_planes();
    send_box('0);
    send_box({COORD_COUNT{16'h7fff}});
    send_box({COORD_COUNT{16'h8000}});
    drain_results();
  endtask

  task automatic test_cube_edges();
    load_cube(1600);
    send_box(make_box(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_box(make_box(1500, 0, 0, 100, 0, 0, 0, 0, 0, 0, 0, 0));
    send_box(make_box(1700, 0, 0, 100, 0, 0, 0, 0, 0, 0, 0, 0));
    send_box(make_box(1701, 0, 0, 100, 0, 0, 0, 0, 0, 0, 0, 0));
    send_box(make_box(0, -1701, 0, 0, 0, 0, 0, -100, 0, 0, 0, 0));
    send_box(make_box(0, 0, 1400, -50, 60, -70, 30, -40, 50, -20, 10, -90));
    send_box(make_box(0, 0, 0, 1599, 0, 0, 0, 1599, 0, 0, 0, 1599));
    send_box(make_box(0, 0, 0, 1600, 0, 0, 0, 1599, 0, 0, 0, 1599));
    send_box({{9{16'h8000}}, {3{16'h7fff}}});
    send_box({{9{16'h7fff}}, {3{16'h8000}}});
    drain_results();
  endtask

  task automatic test_unused_index();
    write_reg(UNUSED_INDEX_LO, {PLANE_BITS{1'b1}});
    write_reg(UNUSED_INDEX_HI, pack_plane(0, 0, 0, 16'h8000));
    cfg_valid <= 1'b0;
    @(negedge clk);
    send_box(make_box(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_box(make_box(1701, 0, 0, 100, 0, 0, 0, 0, 0, 0, 0, 0));
    drain_results();
  endtask

  task automatic test_extreme_planes();
    logic [COEF_BITS-1:0] extremes [3] = '{16'h7fff, 16'h8000, 16'hffff};
    foreach (extremes[e]) begin
      load_uniform(extremes[e]);
      for (int i = 0; i < 10; i++) send_box(i % 2 ? wild_box() : near_box(2000, 400));
      drain_results();
    end
  endtask

  task automatic test_cube_random();
    load_cube($urandom_range(400, 3000));
    for (int i = 0; i < 250; i++) send_box(i % 5 == 4 ? wild_box() : near_box(4000, 1200));
    drain_results();
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    for (int i = 0; i < 100; i++) send_box(i % 4 == 3 ? wild_box() : near_box(4000, 1200));
    drain_results();
    idle_on = 1'b1;
  endtask

  task automatic test_output_stall();
    hold_left = 80;
    for (int i = 0; i < 40; i++) send_box(near_box(4000, 1200));
    drain_results();
  endtask

  task automatic test_random_planes();
    logic [PLANE_BITS-1:0] planes [REG_COUNT];
    for (int round = 0; round < 3; round++) begin
      foreach (planes[p])
        planes[p] = pack_plane(rand_signed(16384), rand_signed(16384), rand_signed(16384),
                               rand_signed(round == 0 ? 4000 : 32767));
      if (round == 2) foreach (planes[p]) planes[p] = {$urandom, $urandom};
      load_planes(planes);
      for (int i = 0; i < 40; i++) send_box(i % 2 ? wild_box() : near_box(3000, 800));
      drain_results();
    end
  endtask

  initial begin
    foreach (plane_word[p]) plane_word[p] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_planes();
    test_cube_edges();
    test_unused_index();
    test_extreme_planes();
    test_cube_random();
    test_back_to_back();
    test_output_stall();
    test_random_planes();
    $display("Classified %0d boxes across %0d plane settings plus reset values.",
             boxes_sent, plane_settings);
    $display("Placements seen: %0d front, %0d back, %0d spanning; %0d mismatches.",
             seen_front, seen_back, seen_span, mismatches);
    if (mismatches == 0) begin
      $display("tb_obb_frustum_classify: clean");
    end else begin
      $display("tb_obb_frustum_classify: errors");
    end
    $finish;
  end

endmodule
